FILE: rtl/varint_field_serializer_defines.svh
// ----------------------------------------------------------------------------
// varint_field_serializer_defines.svh
// Assertion macros used by the checker file of the serializer.
// ----------------------------------------------------------------------------
`ifndef VARINT_FIELD_SERIALIZER_DEFINES_SVH
`define VARINT_FIELD_SERIALIZER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define VFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define VFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define VFS_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_pkg
// Types, codes and constants shared by the serializer modules.
// ----------------------------------------------------------------------------
package vfs_pkg;

  localparam int RAW_BYTES = 8;
  localparam int CNT_W     = 4;

  // Format selector codes.
  localparam logic [2:0] FUNC_RAW8  = 3'd0;
  localparam logic [2:0] FUNC_WORD  = 3'd1;
  localparam logic [2:0] FUNC_UVAR  = 3'd2;
  localparam logic [2:0] FUNC_SVAR  = 3'd3;
  localparam logic [2:0] FUNC_RAW64 = 3'd4;

  typedef enum logic [1:0] {
    KIND_RAW,
    KIND_UVAR,
    KIND_SVAR
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAW,
    ST_UVAR,
    ST_SVAR
  } back_state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic [63:0] offset;
  } out_item_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    kind_t            kind;
    logic             sign;
    logic [CNT_W-1:0] cnt;
    logic [63:0]      mag;
  } cmd_t;

endpackage

FILE: rtl/varint_field_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_field_serializer
// Turns each value into a run of encoded bytes with a running stream offset.
// ----------------------------------------------------------------------------
// Usage: the input side is a queue write port. An item (format selector and
// 64-bit value) is taken at a clock edge where push is high and full is low.
// The result side is a queue read port: while empty is low, out_item shows
// the oldest byte with its last flag and stream offset, and pop takes it.
// Each item yields one byte per cycle while the receiver keeps popping:
// 1 byte for a raw byte, 2 for a word, 8 for eight raw bytes and 1 to 10
// for a varint. The first byte of an item passes through the command
// queue, the byte engine registers and the result register. Back-to-back
// items follow without a gap.
// Items with an unused selector are taken and produce nothing.
// Reset clears the queue, the byte engine and the stream offset to zero.
// When the receiver stops popping, the byte engine waits on the result
// register, the two-entry command queue fills, and then full rises.
// ----------------------------------------------------------------------------
module varint_field_serializer
  import vfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  // Front: classify the format and negate a negative signed value.
  vfs_front u_front (
    .push    (push),
    .q_full  (q_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_cmd   (q_wr_cmd)
  );

  // The input side stalls only on a full command queue.
  assign full = q_full;

  vfs_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_rd_cmd)
  );

  // Back: one byte per cycle into the result register, unless the receiver stalls.
  vfs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (q_rd_cmd),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

FILE: rtl/vfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_front
// Accepts items, classifies the format and prepares the magnitude.
// ----------------------------------------------------------------------------
module vfs_front
  import vfs_pkg::*;
(
  input  logic     push,
  input  logic     q_full,
  input  in_item_t in_item,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic        neg;
  logic [63:0] neg_mag;

  assign neg     = in_item.value[63];
  assign neg_mag = (~in_item.value) + 64'd1;

  always_comb begin
    q_cmd      = '0;
    q_cmd.kind = KIND_RAW;
    q_push     = push && !q_full;
    unique case (in_item.func)
      FUNC_RAW8: begin
        q_cmd.cnt = CNT_W'(1);
        q_cmd.mag = {56'd0, in_item.value[7:0]};
      end
      FUNC_WORD: begin
        // Byte-swapped so the back can always send low byte first.
        q_cmd.cnt = CNT_W'(2);
        q_cmd.mag = {48'd0, in_item.value[7:0], in_item.value[15:8]};
      end
      FUNC_UVAR: begin
        q_cmd.kind = KIND_UVAR;
        q_cmd.mag  = in_item.value;
      end
      FUNC_SVAR: begin
        q_cmd.kind = KIND_SVAR;
        q_cmd.sign = neg;
        q_cmd.mag  = neg ? neg_mag : in_item.value;
      end
      FUNC_RAW64: begin
        q_cmd.cnt = CNT_W'(RAW_BYTES);
        q_cmd.mag = in_item.value;
      end
      default: begin
        // Unused selectors are taken and dropped.
        q_push = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/vfs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module vfs_fifo
  import vfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output logic empty,
  output cmd_t rd_cmd
);

  cmd_t       slots_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_wr;
  logic       do_rd;

  assign full   = (count_r == 2'd2);
  assign empty  = (count_r == 2'd0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: rtl/vfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_back
// Walks one command into the result output register, a byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module vfs_back
  import vfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  back_state_t      state_r, state_nxt;
  logic [63:0]      mag_r, mag_nxt;
  logic             sign_r, sign_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      offset_r, offset_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic        adv;
  logic        take;
  logic [7:0]  cur_byte;
  logic        cur_last;
  logic [63:0] rest;
  logic        cont;

  assign adv   = (state_r != ST_IDLE) && (!out_valid_r || pop);
  assign take  = !q_empty && ((state_r == ST_IDLE) || (adv && cur_last));
  assign q_pop = take;

  // Current byte, its last flag and the remaining magnitude.
  always_comb begin
    cur_byte = 8'd0;
    cur_last = 1'b0;
    rest     = mag_r;
    cont     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cur_last = 1'b0;
      end
      ST_RAW: begin
        cur_byte = mag_r[7:0];
        cur_last = (cnt_r == CNT_W'(1));
        rest     = mag_r >> 8;
      end
      ST_UVAR: begin
        rest     = mag_r >> 7;
        cont     = |rest;
        cur_byte = {mag_r[6:0], cont};
        cur_last = !cont;
      end
      ST_SVAR: begin
        rest     = mag_r >> 6;
        cont     = |rest;
        cur_byte = {sign_r, mag_r[5:0], cont};
        cur_last = !cont;
      end
      default: begin
        cur_last = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (take) begin
      unique case (q_cmd.kind)
        KIND_RAW:  state_nxt = ST_RAW;
        KIND_UVAR: state_nxt = ST_UVAR;
        KIND_SVAR: state_nxt = ST_SVAR;
        default:   state_nxt = ST_IDLE;
      endcase
    end else if (adv) begin
      if (cur_last) begin
        state_nxt = ST_IDLE;
      end else if (state_r == ST_SVAR) begin
        state_nxt = ST_UVAR;
      end
    end
  end

  // Datapath and output register.
  always_comb begin
    mag_nxt       = mag_r;
    sign_nxt      = sign_r;
    cnt_nxt       = cnt_r;
    offset_nxt    = offset_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (take) begin
      mag_nxt  = q_cmd.mag;
      sign_nxt = q_cmd.sign;
      cnt_nxt  = q_cmd.cnt;
    end else if (adv) begin
      mag_nxt = rest;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (adv) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.out_byte = cur_byte;
      out_item_nxt.last     = cur_last;
      out_item_nxt.offset   = offset_r;
      offset_nxt            = offset_r + 64'd1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    sign_r     <= sign_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

endmodule

FILE: rtl/vfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_checker
// Port-level checks on the serializer, bound to the top level.
// ----------------------------------------------------------------------------
`include "varint_field_serializer_defines.svh"

module vfs_checker
  import vfs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  `VFS_ASSERT_RESET(a_empty_after_reset, !rst_n, empty, "results present after reset")
  `VFS_ASSERT_RESET(a_room_after_reset, !rst_n, !full, "input full after reset")
  `VFS_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_item), "stalled item changed")
  `VFS_ASSERT_NEXT(a_offset_steps, !empty && pop, empty || (out_item.offset == $past(out_item.offset) + 64'd1), "offset skipped")

endmodule

bind varint_field_serializer vfs_checker u_vfs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the varint field serializer.
// ----------------------------------------------------------------------------
// Items are pushed through the queue-style input, and each one is encoded
// here into the byte run that the block should produce. The encoder covers
// raw byte, big-endian word, unsigned and sign-magnitude varints, and eight
// raw bytes, and it keeps its own running stream offset. Each byte that is
// popped is checked against the oldest predicted byte. Each byte is checked
// for its value, its last flag and its offset. Both sides pause at random.
// ----------------------------------------------------------------------------
module testbench;
  import vfs_pkg::*;

  // Selector codes that the block takes but that yield no bytes.
  localparam logic [2:0] FUNC_SPARE5 = 3'd5;
  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;

  localparam logic [2:0] USED_FUNCS [5] =
    '{FUNC_RAW8, FUNC_WORD, FUNC_UVAR, FUNC_SVAR, FUNC_RAW64};
  localparam logic [2:0] SPARE_FUNCS [3] = '{FUNC_SPARE5, FUNC_SPARE6, FUNC_SPARE7};

  // Idle cycles are waited at the end so that any stray byte still shows up.
  localparam int TAIL_CYCLES = 20;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  // Predicted bytes in stream order, and the offset of the next one.
  out_item_t   expected_bytes[$];
  logic [63:0] stream_offset = '0;

  int mismatch_count = 0;

  // While this is set, neither side pauses between items.
  bit steady = 1'b0;

  // Receiver pause state.
  int pop_gap = 0;

  varint_field_serializer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every run must finish well inside this time. The worst case per item is
  // ten bytes, each held up by the longest receiver stall, plus the longest
  // sender gap.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Number of idle cycles before the next item or pop.
  function automatic int draw_gap();
    if (steady) begin
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Appends 7-bit groups, low group first. Bit 0 of each byte flags that
  // more groups follow.
  function automatic void push_groups(logic [63:0] mag, ref logic [7:0] run[$]);
    while (mag != '0) begin
      run.push_back({mag[6:0], |mag[63:7]});
      mag = mag >> 7;
    end
  endfunction

  // Works out the byte run for one accepted item and queues it with offsets.
  function automatic void encode_item(in_item_t item);
    logic [7:0]  run[$];
    logic [63:0] mag;
    logic        sign;
    out_item_t   next_byte;
    case (item.func)
      FUNC_RAW8: begin
        run.push_back(item.value[7:0]);
      end
      FUNC_WORD: begin
        run.push_back(item.value[15:8]);
        run.push_back(item.value[7:0]);
      end
      FUNC_UVAR: begin
        if (item.value == '0) begin
          run.push_back(8'h00);
        end else begin
          push_groups(item.value, run);
        end
      end
      FUNC_SVAR: begin
        // Sign and magnitude. Negating the most negative value gives 2^63,
        // which is exactly the unsigned magnitude that is wanted.
        sign = item.value[63];
        mag  = sign ? -item.value : item.value;
        if (mag == '0) begin
          run.push_back(8'h00);
        end else begin
          run.push_back({sign, mag[5:0], |mag[63:6]});
          push_groups(mag >> 6, run);
        end
      end
      FUNC_RAW64: begin
        for (int k = 0; k < RAW_BYTES; k++) begin
          run.push_back(item.value[8*k +: 8]);
        end
      end
      default: begin
      end
    endcase
    foreach (run[k]) begin
      next_byte.out_byte = run[k];
      next_byte.last     = (k == run.size() - 1);
      next_byte.offset   = stream_offset;
      stream_offset      = stream_offset + 64'd1;
      expected_bytes.push_back(next_byte);
    end
  endfunction

  // Byte checker and receiver. Outputs are sampled at the clock edge. A byte
  // counts as taken when pop is high and empty is low. After each byte, the
  // receiver draws a pause before it pops again.
  always @(posedge clk) begin : byte_checker
    out_item_t want;
    logic      taken;
    int        gap;
    if (!rst_n) begin
      pop     <= 1'b0;
      pop_gap <= 0;
    end else begin
      taken = pop && !empty;
      if (taken) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: byte with nothing predicted: expected none, actual %h",
                   $time, out_item);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (want.out_byte !== out_item.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.out_byte, out_item.out_byte);
            mismatch_count++;
          end
          if (want.last !== out_item.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, out_item.last);
            mismatch_count++;
          end
          if (want.offset !== out_item.offset) begin
            $display("%0t: offset mismatch: expected %h, actual %h",
                     $time, want.offset, out_item.offset);
            mismatch_count++;
          end
        end
        gap = draw_gap();
        pop     <= (gap == 0);
        pop_gap <= gap;
      end else if (pop_gap > 0) begin
        pop     <= (pop_gap == 1);
        pop_gap <= pop_gap - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offers one item after a random pause and returns at the edge at which it
  // is taken. Push stays high when the next call does not pause, so a
  // back-to-back stream never lowers it.
  task automatic send_item(input logic [2:0] func, input logic [63:0] value);
    in_item_t item;
    int       gap;
    item.func  = func;
    item.value = value;
    gap = draw_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_item(item);
  endtask

  // Stops sending and waits until every predicted byte has been popped.
  task automatic wait_for_drain();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Random value with a random bit length, sometimes negated, sometimes an
  // extreme. Short values give every varint length.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      default: begin
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // Mostly real formats, with an occasional unused selector as noise.
  function automatic logic [2:0] random_func();
    if ($urandom_range(0, 19) == 0) begin
      return SPARE_FUNCS[$urandom_range(0, $size(SPARE_FUNCS) - 1)];
    end
    return USED_FUNCS[$urandom_range(0, $size(USED_FUNCS) - 1)];
  endfunction

  // Raw byte, word and eight raw bytes. The upper bits that should be
  // dropped are set.
  task automatic test_fixed_formats();
    send_item(FUNC_RAW8, 64'h0000_0000_0000_0000);
    send_item(FUNC_RAW8, 64'hFFFF_FFFF_FFFF_FF5A);
    send_item(FUNC_WORD, 64'h0000_0000_0000_0000);
    send_item(FUNC_WORD, 64'h0000_0000_0000_FFFF);
    send_item(FUNC_WORD, 64'hA5A5_0000_1234_BEEF);
    send_item(FUNC_RAW64, 64'h0000_0000_0000_0000);
    send_item(FUNC_RAW64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FUNC_RAW64, 64'h0123_4567_89AB_CDEF);
  endtask

  // Unsigned varint: zero, the one- and two-byte boundary, and the longest
  // runs.
  task automatic test_unsigned_varint();
    send_item(FUNC_UVAR, 64'd0);
    send_item(FUNC_UVAR, 64'd1);
    send_item(FUNC_UVAR, 64'd127);
    send_item(FUNC_UVAR, 64'd128);
    send_item(FUNC_UVAR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FUNC_UVAR, 64'h8000_0000_0000_0000);
  endtask

  // Signed varint: zero, both signs at the six-bit boundary, the largest
  // positive value, and the most negative value, whose magnitude is 2^63.
  task automatic test_signed_varint();
    send_item(FUNC_SVAR, 64'd0);
    send_item(FUNC_SVAR, 64'd1);
    send_item(FUNC_SVAR, -64'd1);
    send_item(FUNC_SVAR, 64'd63);
    send_item(FUNC_SVAR, 64'd64);
    send_item(FUNC_SVAR, -64'd64);
    send_item(FUNC_SVAR, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(FUNC_SVAR, 64'h8000_0000_0000_0000);
  endtask

  // Unused selectors are taken but must add no bytes and must not move the
  // offset.
  task automatic test_spare_selectors();
    send_item(FUNC_SPARE5, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FUNC_SPARE6, 64'h0000_0000_0000_0001);
    send_item(FUNC_SPARE7, 64'h8000_0000_0000_0000);
  endtask

  // The sender stops until the block has fully drained, then starts again.
  // Long runs are used on both sides of the pause.
  task automatic test_drain_pause();
    send_item(FUNC_UVAR, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(FUNC_SVAR, 64'h8000_0000_0000_0000);
    wait_for_drain();
    send_item(FUNC_RAW64, random_value());
    send_item(FUNC_SVAR, random_value());
  endtask

  // No pauses on either side. The command queue fills and full has to hold
  // the sender back.
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (30) send_item(random_func(), random_value());
    steady = 1'b0;
  endtask

  // Random formats and values. Now and then, a stretch runs with no pauses.
  task automatic test_random_mix(input int count);
    logic [2:0] func;
    int         sent;
    sent = 0;
    while (sent < count) begin
      if (sent % 60 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      func = random_func();
      send_item(func, random_value());
      if (func <= FUNC_RAW64) begin
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fixed_formats();
    test_unsigned_varint();
    test_signed_varint();
    test_spare_selectors();
    test_drain_pause();
    test_back_to_back();
    test_random_mix(420);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
